// ===== hw/rtl/ttg_pkg.sv =====
package ttg_pkg;

  // Field widths and fixed-point format.
  localparam int POS_BITS  = 24;
  localparam int UV_BITS   = 20;
  localparam int NRM_BITS  = 18;
  localparam int TAN_BITS  = 18;
  localparam int FRAC_BITS = 16;

  // Internal widths, all but MAG_BITS derived from the field widths.
  localparam int EDGE_W   = POS_BITS + 1;
  localparam int UVD_W    = UV_BITS + 1;
  localparam int PROD_W   = EDGE_W + UVD_W;
  localparam int VEC_W    = PROD_W + 2;
  localparam int MAG_BITS = 30;
  localparam int SQ_W     = 2 * MAG_BITS + 2;
  localparam int SQRT_W   = SQ_W + 2;
  localparam int LEN_W    = MAG_BITS + 1;
  localparam int QUO_W    = FRAC_BITS + 1;
  localparam int NUM_W    = MAG_BITS + FRAC_BITS + 1;
  localparam int REM_W    = LEN_W + 1;
  localparam int CROSS_W  = 2 * TAN_BITS - 1;
  localparam int HPROD_W  = NRM_BITS + CROSS_W;
  localparam int DOT_W    = HPROD_W + 2;

  localparam int STEP_W     = 6;
  localparam int PAIR_IDX_W = 4;

  // Products a*b - c*d run on the shared pair multiplier.
  localparam logic [PAIR_IDX_W-1:0] PAIR_DET = 4'd0;
  localparam logic [PAIR_IDX_W-1:0] PAIR_SD0 = 4'd1;
  localparam logic [PAIR_IDX_W-1:0] PAIR_SD1 = 4'd2;
  localparam logic [PAIR_IDX_W-1:0] PAIR_SD2 = 4'd3;
  localparam logic [PAIR_IDX_W-1:0] PAIR_TD0 = 4'd4;
  localparam logic [PAIR_IDX_W-1:0] PAIR_TD1 = 4'd5;
  localparam logic [PAIR_IDX_W-1:0] PAIR_TD2 = 4'd6;
  localparam logic [PAIR_IDX_W-1:0] PAIR_W0  = 4'd7;
  localparam logic [PAIR_IDX_W-1:0] PAIR_W1  = 4'd8;
  localparam logic [PAIR_IDX_W-1:0] PAIR_W2  = 4'd9;

  // Sequencer step limits.
  localparam logic [STEP_W-1:0] PAIR_LAST  = STEP_W'(7);
  localparam logic [STEP_W-1:0] TRIO_LAST  = STEP_W'(3);
  localparam logic [STEP_W-1:0] SQRT_LAST  = STEP_W'(SQRT_W / 2);
  localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(QUO_W + 1);

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_DELTA,
    ST_PAIR,
    ST_NLOAD,
    ST_NSHIFT,
    ST_NSQ,
    ST_NSQRT,
    ST_NDIV,
    ST_CROSS,
    ST_HAND,
    ST_EMIT
  } ttg_state_t;

  typedef struct packed {
    logic                  held_we;
    logic [1:0]            held_idx;
    logic                  delta_en;
    logic                  pair_issue;
    logic [PAIR_IDX_W-1:0] pair_issue_idx;
    logic                  pair_wr;
    logic [PAIR_IDX_W-1:0] pair_wr_idx;
    logic                  norm_sel;
    logic                  norm_load;
    logic                  norm_shift;
    logic                  sq_issue;
    logic [1:0]            sq_idx;
    logic                  sq_acc;
    logic                  sqrt_start;
    logic                  sqrt_step;
    logic                  div_start;
    logic                  div_step;
    logic                  div_wr;
    logic [1:0]            div_idx;
    logic                  hand_issue;
    logic [1:0]            hand_issue_idx;
    logic                  hand_wr;
    logic [1:0]            hand_wr_idx;
    logic [1:0]            out_idx;
  } ttg_cmd_t;

  typedef struct packed {
    logic shift_done;
  } ttg_status_t;

endpackage

// ===== hw/rtl/ttg_ctrl.sv =====
module ttg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           corner,
  output logic                 last,
  input  ttg_pkg::ttg_status_t status,
  output ttg_pkg::ttg_cmd_t    cmd
);

  ttg_pkg::ttg_state_t state, state_next;
  logic [ttg_pkg::STEP_W-1:0] step, step_next;
  logic [1:0] corner_count, corner_count_next;
  logic       norm_sel, norm_sel_next;
  logic [1:0] div_idx, div_idx_next;
  logic [1:0] out_idx, out_idx_next;
  logic       in_open, in_acc, out_acc, third;

  // Corners 0 and 1 of the next triangle may be taken while results drain.
  assign in_open = (state == ttg_pkg::ST_COLLECT) ||
                   (state == ttg_pkg::ST_EMIT && corner_count < 2'd2);
  assign in_stall = !in_open;
  assign in_acc   = in_valid && in_open;
  assign out_acc  = out_valid && !out_stall;
  assign third    = corner_count >= 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ttg_pkg::ST_COLLECT;
      step         <= '0;
      corner_count <= '0;
      norm_sel     <= 1'b0;
      div_idx      <= '0;
      out_idx      <= '0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      corner_count <= corner_count_next;
      norm_sel     <= norm_sel_next;
      div_idx      <= div_idx_next;
      out_idx      <= out_idx_next;
    end
  end

  always_comb begin
    state_next        = state;
    step_next         = step;
    corner_count_next = corner_count;
    norm_sel_next     = norm_sel;
    div_idx_next      = div_idx;
    out_idx_next      = out_idx;
    if (in_acc) begin
      corner_count_next = third ? 2'd0 : corner_count + 2'd1;
    end
    unique case (state)
      ttg_pkg::ST_COLLECT: begin
        if (in_acc && third) begin
          state_next = ttg_pkg::ST_DELTA;
        end
      end
      ttg_pkg::ST_DELTA: begin
        state_next = ttg_pkg::ST_PAIR;
        step_next  = '0;
      end
      ttg_pkg::ST_PAIR: begin
        if (step == ttg_pkg::PAIR_LAST) begin
          state_next    = ttg_pkg::ST_NLOAD;
          norm_sel_next = 1'b0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ttg_pkg::ST_NLOAD: begin
        state_next = ttg_pkg::ST_NSHIFT;
      end
      ttg_pkg::ST_NSHIFT: begin
        if (status.shift_done) begin
          state_next = ttg_pkg::ST_NSQ;
          step_next  = '0;
        end
      end
      ttg_pkg::ST_NSQ: begin
        if (step == ttg_pkg::TRIO_LAST) begin
          state_next = ttg_pkg::ST_NSQRT;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ttg_pkg::ST_NSQRT: begin
        if (step == ttg_pkg::SQRT_LAST) begin
          state_next   = ttg_pkg::ST_NDIV;
          step_next    = '0;
          div_idx_next = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ttg_pkg::ST_NDIV: begin
        if (step == ttg_pkg::DIV_LAST) begin
          step_next = '0;
          if (div_idx == 2'd2) begin
            if (!norm_sel) begin
              norm_sel_next = 1'b1;
              state_next    = ttg_pkg::ST_NLOAD;
            end else begin
              state_next = ttg_pkg::ST_CROSS;
            end
          end else begin
            div_idx_next = div_idx + 2'd1;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      ttg_pkg::ST_CROSS: begin
        if (step == ttg_pkg::TRIO_LAST) begin
          state_next = ttg_pkg::ST_HAND;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ttg_pkg::ST_HAND: begin
        if (step == ttg_pkg::TRIO_LAST) begin
          state_next   = ttg_pkg::ST_EMIT;
          out_idx_next = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ttg_pkg::ST_EMIT: begin
        if (out_acc) begin
          if (out_idx == 2'd2) begin
            state_next = ttg_pkg::ST_COLLECT;
          end else begin
            out_idx_next = out_idx + 2'd1;
          end
        end
      end
      default: begin
        state_next = ttg_pkg::ST_COLLECT;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    out_valid    = 1'b0;
    cmd.held_we  = in_acc;
    cmd.held_idx = third ? 2'd2 : corner_count;
    cmd.norm_sel = norm_sel;
    cmd.div_idx  = div_idx;
    cmd.out_idx  = out_idx;
    unique case (state)
      ttg_pkg::ST_COLLECT: begin
      end
      ttg_pkg::ST_DELTA: begin
        cmd.delta_en = 1'b1;
      end
      ttg_pkg::ST_PAIR: begin
        cmd.pair_issue     = step < ttg_pkg::PAIR_LAST;
        cmd.pair_issue_idx = ttg_pkg::PAIR_IDX_W'(step);
        cmd.pair_wr        = step != '0;
        cmd.pair_wr_idx    = ttg_pkg::PAIR_IDX_W'(step - 1'b1);
      end
      ttg_pkg::ST_NLOAD: begin
        cmd.norm_load = 1'b1;
      end
      ttg_pkg::ST_NSHIFT: begin
        cmd.norm_shift = !status.shift_done;
      end
      ttg_pkg::ST_NSQ: begin
        cmd.sq_issue = step < ttg_pkg::TRIO_LAST;
        cmd.sq_idx   = step[1:0];
        cmd.sq_acc   = step != '0;
      end
      ttg_pkg::ST_NSQRT: begin
        cmd.sqrt_start = step == '0;
        cmd.sqrt_step  = step != '0;
      end
      ttg_pkg::ST_NDIV: begin
        cmd.div_start = step == '0;
        cmd.div_step  = step != '0 && step != ttg_pkg::DIV_LAST;
        cmd.div_wr    = step == ttg_pkg::DIV_LAST;
      end
      ttg_pkg::ST_CROSS: begin
        cmd.pair_issue     = step < ttg_pkg::TRIO_LAST;
        cmd.pair_issue_idx = ttg_pkg::PAIR_IDX_W'(ttg_pkg::PAIR_W0 + step);
        cmd.pair_wr        = step != '0;
        cmd.pair_wr_idx    = ttg_pkg::PAIR_IDX_W'(ttg_pkg::PAIR_W0 + step - 1'b1);
      end
      ttg_pkg::ST_HAND: begin
        cmd.hand_issue     = step < ttg_pkg::TRIO_LAST;
        cmd.hand_issue_idx = step[1:0];
        cmd.hand_wr        = step != '0;
        cmd.hand_wr_idx    = 2'(step - 1'b1);
      end
      ttg_pkg::ST_EMIT: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign corner = out_idx;
  assign last   = out_idx == 2'd2;

  a_in_only_when_open: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (state == ttg_pkg::ST_COLLECT || state == ttg_pkg::ST_EMIT))
    else $error("input word taken while the datapath is busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    corner_count != 2'd3)
    else $error("corner count out of range");

  a_third_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && corner_count == 2'd2) |=> state == ttg_pkg::ST_DELTA)
    else $error("third corner did not start the computation");

  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_idx == 2'd2) |=> state == ttg_pkg::ST_COLLECT)
    else $error("last result did not return to collecting");

endmodule

// ===== hw/rtl/ttg_datapath.sv =====
module ttg_datapath (
  input  logic                                 clk,
  input  ttg_pkg::ttg_cmd_t                    cmd,
  output ttg_pkg::ttg_status_t                 status,
  input  logic signed [ttg_pkg::POS_BITS-1:0]  pos_x,
  input  logic signed [ttg_pkg::POS_BITS-1:0]  pos_y,
  input  logic signed [ttg_pkg::POS_BITS-1:0]  pos_z,
  input  logic signed [ttg_pkg::UV_BITS-1:0]   tex_u,
  input  logic signed [ttg_pkg::UV_BITS-1:0]   tex_v,
  input  logic signed [ttg_pkg::NRM_BITS-1:0]  normal_x,
  input  logic signed [ttg_pkg::NRM_BITS-1:0]  normal_y,
  input  logic signed [ttg_pkg::NRM_BITS-1:0]  normal_z,
  output logic signed [ttg_pkg::TAN_BITS-1:0]  tangent_x,
  output logic signed [ttg_pkg::TAN_BITS-1:0]  tangent_y,
  output logic signed [ttg_pkg::TAN_BITS-1:0]  tangent_z,
  output logic                                 handedness,
  output logic                                 degenerate
);

  localparam int EW = ttg_pkg::EDGE_W;
  localparam int UW = ttg_pkg::UVD_W;
  localparam int VW = ttg_pkg::VEC_W;
  localparam int MB = ttg_pkg::MAG_BITS;

  logic signed [ttg_pkg::POS_BITS-1:0] pos [3][3];
  logic signed [ttg_pkg::UV_BITS-1:0]  uv  [3][2];
  logic signed [ttg_pkg::NRM_BITS-1:0] nrm [3][3];

  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [UW-1:0] s1, s2, t1, t2;

  logic signed [EW-1:0] op_a, op_c;
  logic signed [UW-1:0] op_b, op_d;
  logic signed [ttg_pkg::PROD_W-1:0] prod_a, prod_b;
  logic signed [VW-1:0] pair_diff, pair_fix;
  logic det_neg;

  logic signed [VW-1:0] sd [3];
  logic signed [VW-1:0] td [3];
  logic signed [VW-1:0] vsel [3];
  logic [VW-1:0] mag [3];
  logic          neg [3];

  logic [2*MB-1:0]              sq_prod;
  logic [ttg_pkg::SQ_W-1:0]     sum;
  logic [ttg_pkg::SQRT_W-1:0]   rx, root, rbit, rtry;
  logic [ttg_pkg::LEN_W-1:0]    len;

  logic [ttg_pkg::NUM_W-1:0]    num;
  logic [ttg_pkg::REM_W-1:0]    rem, trial;
  logic [ttg_pkg::QUO_W-1:0]    dlo, quo;
  logic signed [ttg_pkg::TAN_BITS-1:0] div_val;

  logic signed [ttg_pkg::TAN_BITS-1:0] sn [3];
  logic signed [ttg_pkg::TAN_BITS-1:0] tn [3];
  logic signed [ttg_pkg::CROSS_W-1:0]  w  [3];
  logic signed [ttg_pkg::HPROD_W-1:0]  hp [3];
  logic signed [ttg_pkg::DOT_W-1:0]    dot;
  logic hand [3];
  logic degen;

  always_ff @(posedge clk) begin
    if (cmd.held_we) begin
      pos[cmd.held_idx][0] <= pos_x;
      pos[cmd.held_idx][1] <= pos_y;
      pos[cmd.held_idx][2] <= pos_z;
      uv[cmd.held_idx][0]  <= tex_u;
      uv[cmd.held_idx][1]  <= tex_v;
      nrm[cmd.held_idx][0] <= normal_x;
      nrm[cmd.held_idx][1] <= normal_y;
      nrm[cmd.held_idx][2] <= normal_z;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.delta_en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EW'(pos[1][i]) - EW'(pos[0][i]);
        e2[i] <= EW'(pos[2][i]) - EW'(pos[0][i]);
      end
      s1 <= UW'(uv[1][0]) - UW'(uv[0][0]);
      s2 <= UW'(uv[2][0]) - UW'(uv[0][0]);
      t1 <= UW'(uv[1][1]) - UW'(uv[0][1]);
      t2 <= UW'(uv[2][1]) - UW'(uv[0][1]);
    end
  end

  // Operand selection for the shared a*b - c*d unit.
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_c = '0;
    op_d = '0;
    case (cmd.pair_issue_idx)
      ttg_pkg::PAIR_DET: begin
        op_a = EW'(s1); op_b = t2; op_c = EW'(s2); op_d = t1;
      end
      ttg_pkg::PAIR_SD0: begin op_a = e1[0]; op_b = t2; op_c = e2[0]; op_d = t1; end
      ttg_pkg::PAIR_SD1: begin op_a = e1[1]; op_b = t2; op_c = e2[1]; op_d = t1; end
      ttg_pkg::PAIR_SD2: begin op_a = e1[2]; op_b = t2; op_c = e2[2]; op_d = t1; end
      ttg_pkg::PAIR_TD0: begin op_a = e2[0]; op_b = s1; op_c = e1[0]; op_d = s2; end
      ttg_pkg::PAIR_TD1: begin op_a = e2[1]; op_b = s1; op_c = e1[1]; op_d = s2; end
      ttg_pkg::PAIR_TD2: begin op_a = e2[2]; op_b = s1; op_c = e1[2]; op_d = s2; end
      ttg_pkg::PAIR_W0: begin
        op_a = EW'(sn[1]); op_b = UW'(tn[2]); op_c = EW'(sn[2]); op_d = UW'(tn[1]);
      end
      ttg_pkg::PAIR_W1: begin
        op_a = EW'(sn[2]); op_b = UW'(tn[0]); op_c = EW'(sn[0]); op_d = UW'(tn[2]);
      end
      ttg_pkg::PAIR_W2: begin
        op_a = EW'(sn[0]); op_b = UW'(tn[1]); op_c = EW'(sn[1]); op_d = UW'(tn[0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pair_issue) begin
      prod_a <= op_a * op_b;
      prod_b <= op_c * op_d;
    end
  end

  assign pair_diff = VW'(prod_a) - VW'(prod_b);
  // Only the sign of 1/det survives normalisation, so a negative det flips both directions.
  assign pair_fix  = det_neg ? -pair_diff : pair_diff;

  always_ff @(posedge clk) begin
    if (cmd.pair_wr) begin
      case (cmd.pair_wr_idx)
        ttg_pkg::PAIR_DET: det_neg <= pair_diff[VW-1];
        ttg_pkg::PAIR_SD0: sd[0] <= pair_fix;
        ttg_pkg::PAIR_SD1: sd[1] <= pair_fix;
        ttg_pkg::PAIR_SD2: sd[2] <= pair_fix;
        ttg_pkg::PAIR_TD0: td[0] <= pair_fix;
        ttg_pkg::PAIR_TD1: td[1] <= pair_fix;
        ttg_pkg::PAIR_TD2: td[2] <= pair_fix;
        ttg_pkg::PAIR_W0:  w[0] <= pair_diff[ttg_pkg::CROSS_W-1:0];
        ttg_pkg::PAIR_W1:  w[1] <= pair_diff[ttg_pkg::CROSS_W-1:0];
        ttg_pkg::PAIR_W2:  w[2] <= pair_diff[ttg_pkg::CROSS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.delta_en) begin
      degen <= 1'b0;
    end else if (cmd.pair_wr && cmd.pair_wr_idx == ttg_pkg::PAIR_DET && pair_diff == '0) begin
      degen <= 1'b1;
    end else if (cmd.div_start && len == '0) begin
      degen <= 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsel[i] = cmd.norm_sel ? td[i] : sd[i];
    end
  end

  // Magnitudes are shifted one place a cycle until all fit below the square limit.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.norm_load) begin
        mag[i] <= vsel[i][VW-1] ? VW'(-vsel[i]) : VW'(vsel[i]);
        neg[i] <= vsel[i][VW-1];
      end else if (cmd.norm_shift) begin
        mag[i] <= mag[i] >> 1;
      end
    end
  end

  assign status.shift_done = ~|mag[0][VW-1:MB] && ~|mag[1][VW-1:MB] && ~|mag[2][VW-1:MB];

  always_ff @(posedge clk) begin
    if (cmd.sq_issue) begin
      sq_prod <= mag[cmd.sq_idx][MB-1:0] * mag[cmd.sq_idx][MB-1:0];
    end
    if (cmd.norm_load) begin
      sum <= '0;
    end else if (cmd.sq_acc) begin
      sum <= sum + ttg_pkg::SQ_W'(sq_prod);
    end
  end

  // Digit-by-digit square root, one result bit per cycle.
  assign rtry = root + rbit;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rx   <= ttg_pkg::SQRT_W'(sum);
      root <= '0;
      rbit <= ttg_pkg::SQRT_W'(1) << (ttg_pkg::SQRT_W - 2);
    end else if (cmd.sqrt_step) begin
      if (rx >= rtry) begin
        rx   <= rx - rtry;
        root <= (root >> 1) + rbit;
      end else begin
        root <= root >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  assign len = root[ttg_pkg::LEN_W-1:0];

  // Rounded quotient by restoring division; the upper dividend bits are already below len.
  assign num = (ttg_pkg::NUM_W'(mag[cmd.div_idx][MB-1:0]) << ttg_pkg::FRAC_BITS)
             + ttg_pkg::NUM_W'(len[ttg_pkg::LEN_W-1:1]);
  assign trial = {rem[ttg_pkg::LEN_W-1:0], dlo[ttg_pkg::QUO_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= ttg_pkg::REM_W'(num[ttg_pkg::NUM_W-1:ttg_pkg::QUO_W]);
      dlo <= num[ttg_pkg::QUO_W-1:0];
      quo <= '0;
    end else if (cmd.div_step) begin
      if (trial >= ttg_pkg::REM_W'(len)) begin
        rem <= trial - ttg_pkg::REM_W'(len);
        quo <= {quo[ttg_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[ttg_pkg::QUO_W-2:0], 1'b0};
      end
      dlo <= dlo << 1;
    end
  end

  always_comb begin
    div_val = ttg_pkg::TAN_BITS'(quo);
    if (neg[cmd.div_idx]) begin
      div_val = -ttg_pkg::TAN_BITS'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_wr) begin
      if (cmd.norm_sel) begin
        tn[cmd.div_idx] <= div_val;
      end else begin
        sn[cmd.div_idx] <= div_val;
      end
    end
  end

  // Handedness via the triple product n . (s x t), which equals (n x s) . t exactly.
  always_ff @(posedge clk) begin
    if (cmd.hand_issue) begin
      for (int i = 0; i < 3; i++) begin
        hp[i] <= nrm[cmd.hand_issue_idx][i] * w[i];
      end
    end
  end

  assign dot = ttg_pkg::DOT_W'(hp[0]) + ttg_pkg::DOT_W'(hp[1]) + ttg_pkg::DOT_W'(hp[2]);

  always_ff @(posedge clk) begin
    if (cmd.hand_wr) begin
      hand[cmd.hand_wr_idx] <= !dot[ttg_pkg::DOT_W-1] && (dot != '0);
    end
  end

  assign tangent_x  = degen ? '0 : sn[0];
  assign tangent_y  = degen ? '0 : sn[1];
  assign tangent_z  = degen ? '0 : sn[2];
  assign handedness = !degen && hand[cmd.out_idx];
  assign degenerate = degen;

endmodule

// ===== hw/rtl/triangle_tangent_generator.sv =====
// Channel   Direction  Handshake            Word
// in        input      in_valid/in_stall    one triangle corner
// out       output     out_valid/out_stall  one tangent result
//
// Corners 0 and 1 are stored and give no result.
// The third corner starts the work, in which each direction is first pre-shifted
// (up to 16 places each) and two 25x21 multipliers, a 30-bit squarer, a
// bit-serial square root and a restoring divider (one component at a time, six
// components) are shared in turn.
// Three results follow, one per corner; corners 0 and 1 of the next triangle
// are taken while they drain. Reset returns the corner count to zero.
// A stalled result word holds its value until taken.
module triangle_tangent_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ttg_pkg::POS_BITS-1:0] pos_x,
  input  logic signed [ttg_pkg::POS_BITS-1:0] pos_y,
  input  logic signed [ttg_pkg::POS_BITS-1:0] pos_z,
  input  logic signed [ttg_pkg::UV_BITS-1:0]  tex_u,
  input  logic signed [ttg_pkg::UV_BITS-1:0]  tex_v,
  input  logic signed [ttg_pkg::NRM_BITS-1:0] normal_x,
  input  logic signed [ttg_pkg::NRM_BITS-1:0] normal_y,
  input  logic signed [ttg_pkg::NRM_BITS-1:0] normal_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ttg_pkg::TAN_BITS-1:0] tangent_x,
  output logic signed [ttg_pkg::TAN_BITS-1:0] tangent_y,
  output logic signed [ttg_pkg::TAN_BITS-1:0] tangent_z,
  output logic                                handedness,
  output logic [1:0]                          corner,
  output logic                                last,
  output logic                                degenerate
);

  ttg_pkg::ttg_cmd_t    cmd;
  ttg_pkg::ttg_status_t status;

  ttg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .corner    (corner),
    .last      (last),
    .status    (status),
    .cmd       (cmd)
  );

  ttg_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .tex_u      (tex_u),
    .tex_v      (tex_v),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .tangent_x  (tangent_x),
    .tangent_y  (tangent_y),
    .tangent_z  (tangent_z),
    .handedness (handedness),
    .degenerate (degenerate)
  );

endmodule

// ===== tb/tb_triangle_tangent_generator.sv =====
`timescale 1ns / 1ps

module tb_triangle_tangent_generator;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLDOFF_CYCLES = 1200;
  localparam int RANDOM_TRIS    = 113;

  typedef struct {
    logic signed [ttg_pkg::POS_BITS-1:0] px, py, pz;
    logic signed [ttg_pkg::UV_BITS-1:0]  u, v;
    logic signed [ttg_pkg::NRM_BITS-1:0] nx, ny, nz;
    bit                                  typed;     // expected words typed in below
    logic signed [ttg_pkg::TAN_BITS-1:0] etx, ety, etz;
    bit                                  ehand, edeg;
  } corner_row_t;

  typedef struct {
    logic signed [ttg_pkg::TAN_BITS-1:0] tx, ty, tz;
    logic                                hand;
    logic [1:0]                          idx;
    logic                                lst, deg;
  } tangent_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ttg_pkg::POS_BITS-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [ttg_pkg::UV_BITS-1:0]  tex_u = '0, tex_v = '0;
  logic signed [ttg_pkg::NRM_BITS-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ttg_pkg::TAN_BITS-1:0] tangent_x, tangent_y, tangent_z;
  logic handedness, last, degenerate;
  logic [1:0] corner;

  triangle_tangent_generator dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tangent_word_t pending_tangents[$];
  corner_row_t   held_corners[2];
  int            held_count;
  int            errors;
  int            idle_cycles;
  bit            sending_done;
  bit            holdoff_req;

  corner_row_t directed[] = '{
    // All corners coincide: zero determinant, zero tangent.
    '{'0, '0, '0, '0, '0, '0, '0, '0, 1'b1, '0, '0, '0, 1'b0, 1'b1},
    '{'0, '0, '0, '0, '0, '0, '0, '0, 1'b1, '0, '0, '0, 1'b0, 1'b1},
    '{'0, '0, '0, '0, '0, '0, '0, '0, 1'b1, '0, '0, '0, 1'b0, 1'b1},
    // Unit right triangle aligned with the UV axes, normal along +z.
    '{'0, '0, '0, '0, '0, '0, '0, 18'sh10000, 1'b1, 18'sh10000, '0, '0, 1'b1, 1'b0},
    '{24'sh10000, '0, '0, 20'sh10000, '0, '0, '0, 18'sh10000, 1'b1, 18'sh10000, '0, '0,
      1'b1, 1'b0},
    '{'0, 24'sh10000, '0, '0, 20'sh10000, '0, '0, 18'sh10000, 1'b1, 18'sh10000, '0, '0,
      1'b1, 1'b0},
    // Same triangle with the normal flipped and v mirrored.
    '{'0, '0, '0, '0, '0, '0, '0, -18'sh10000, 1'b0, '0, '0, '0, 1'b0, 1'b0},
    '{24'sh10000, '0, '0, 20'sh10000, '0, '0, '0, -18'sh10000, 1'b0, '0, '0, '0, 1'b0, 1'b0},
    '{'0, 24'sh10000, '0, '0, -20'sh10000, '0, '0, -18'sh10000, 1'b0, '0, '0, '0, 1'b0, 1'b0},
    // Extremes of every field.
    '{24'sh7fffff, 24'sh800000, 24'sh7fffff, 20'sh7ffff, 20'sh80000, 18'sh1ffff, 18'sh20000,
      18'sh1ffff, 1'b0, '0, '0, '0, 1'b0, 1'b0},
    '{24'sh800000, 24'sh7fffff, 24'sh800000, 20'sh80000, 20'sh80000, 18'sh20000, 18'sh1ffff,
      18'sh20000, 1'b0, '0, '0, '0, 1'b0, 1'b0},
    '{24'sh800000, 24'sh800000, 24'sh7fffff, 20'sh7ffff, 20'sh7ffff, 18'sh20000, 18'sh20000,
      18'sh20000, 1'b0, '0, '0, '0, 1'b0, 1'b0},
    // Collinear positions with a good UV map: s and t come out parallel.
    '{'0, '0, '0, '0, '0, '0, 18'sh10000, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0},
    '{24'sh10000, 24'sh10000, '0, 20'sh10000, '0, '0, 18'sh10000, '0, 1'b0, '0, '0, '0,
      1'b0, 1'b0},
    '{24'sh20000, 24'sh20000, '0, '0, 20'sh10000, '0, 18'sh10000, '0, 1'b0, '0, '0, '0,
      1'b0, 1'b0},
    // Swapped UV winding gives a negative determinant.
    '{24'sh1234, -24'sh5678, 24'sh9abc, '0, '0, 18'sh8000, 18'sh8000, 18'sh8000, 1'b0, '0, '0,
      '0, 1'b0, 1'b0},
    '{-24'sh40000, 24'sh11111, 24'sh3000, '0, 20'sh8000, 18'sh8000, 18'sh8000, 18'sh8000, 1'b0,
      '0, '0, '0, 1'b0, 1'b0},
    '{24'sh22222, 24'sh50000, -24'sh7777, 20'sh8000, '0, 18'sh8000, 18'sh8000, 18'sh8000, 1'b0,
      '0, '0, '0, 1'b0, 1'b0},
    // Normals absent on a good triangle.
    '{24'sh100, '0, 24'sh300, 20'sh100, 20'sh200, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0},
    '{24'sh5000, 24'sh70, '0, 20'sh3000, -20'sh100, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0},
    '{-24'sh900, 24'sh4000, 24'sh10, -20'sh700, 20'sh2500, '0, '0, '0, 1'b0, '0, '0, '0,
      1'b0, 1'b0}
  };

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Scales a vector to unit length in Q1.16; returns 0 when it has no length.
  function automatic bit unit_vector(input longint a[3], output longint o[3]);
    longint unsigned mag[3];
    longint unsigned mx, sum, len, q;
    int sh;
    mx = 0;
    sum = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = a[i] < 0 ? -a[i] : a[i];
      if (mag[i] > mx) mx = mag[i];
    end
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= sh;
      sum += mag[i] * mag[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) o[i] = 0;
    if (len == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << ttg_pkg::FRAC_BITS) + len / 2) / len;
      o[i] = a[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  // Takes one accepted corner; on the third it queues the three tangent words.
  function automatic void predict_corner(input corner_row_t c);
    corner_row_t t[3];
    longint e1[3], e2[3], sd[3], td[3], sn[3], tn[3];
    longint s1, s2, t1, t2, det, cx, cy, cz, dot;
    bit degen, ok_s, ok_t;
    tangent_word_t w;
    if (held_count < 2) begin
      held_corners[held_count] = c;
      held_count++;
      return;
    end
    t[0] = held_corners[0];
    t[1] = held_corners[1];
    t[2] = c;
    held_count = 0;
    s1 = longint'(t[1].u) - longint'(t[0].u);
    s2 = longint'(t[2].u) - longint'(t[0].u);
    t1 = longint'(t[1].v) - longint'(t[0].v);
    t2 = longint'(t[2].v) - longint'(t[0].v);
    det = s1 * t2 - s2 * t1;
    e1[0] = longint'(t[1].px) - longint'(t[0].px);
    e1[1] = longint'(t[1].py) - longint'(t[0].py);
    e1[2] = longint'(t[1].pz) - longint'(t[0].pz);
    e2[0] = longint'(t[2].px) - longint'(t[0].px);
    e2[1] = longint'(t[2].py) - longint'(t[0].py);
    e2[2] = longint'(t[2].pz) - longint'(t[0].pz);
    for (int i = 0; i < 3; i++) begin
      sd[i] = t2 * e1[i] - t1 * e2[i];
      td[i] = s1 * e2[i] - s2 * e1[i];
      if (det < 0) begin
        sd[i] = -sd[i];
        td[i] = -td[i];
      end
    end
    ok_s = unit_vector(sd, sn);
    ok_t = unit_vector(td, tn);
    degen = (det == 0) || !ok_s || !ok_t;
    for (int k = 0; k < 3; k++) begin
      w.idx = k[1:0];
      w.lst = (k == 2);
      if (t[2].typed) begin
        w.tx = t[k].etx;
        w.ty = t[k].ety;
        w.tz = t[k].etz;
        w.hand = t[k].ehand;
        w.deg = t[k].edeg;
      end else begin
        w.deg = degen;
        w.tx = degen ? '0 : ttg_pkg::TAN_BITS'(sn[0]);
        w.ty = degen ? '0 : ttg_pkg::TAN_BITS'(sn[1]);
        w.tz = degen ? '0 : ttg_pkg::TAN_BITS'(sn[2]);
        cx = longint'(t[k].ny) * sn[2] - longint'(t[k].nz) * sn[1];
        cy = longint'(t[k].nz) * sn[0] - longint'(t[k].nx) * sn[2];
        cz = longint'(t[k].nx) * sn[1] - longint'(t[k].ny) * sn[0];
        dot = cx * tn[0] + cy * tn[1] + cz * tn[2];
        w.hand = !degen && (dot > 0);
      end
      pending_tangents = {pending_tangents, w};
    end
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic corner_row_t random_corner(input int mode);
    corner_row_t c;
    c = '{default: '0};
    if (mode == 0) begin
      // Full-range fields so that every bit toggles.
      c.px = ttg_pkg::POS_BITS'($urandom);
      c.py = ttg_pkg::POS_BITS'($urandom);
      c.pz = ttg_pkg::POS_BITS'($urandom);
      c.u = ttg_pkg::UV_BITS'($urandom);
      c.v = ttg_pkg::UV_BITS'($urandom);
      c.nx = ttg_pkg::NRM_BITS'($urandom);
      c.ny = ttg_pkg::NRM_BITS'($urandom);
      c.nz = ttg_pkg::NRM_BITS'($urandom);
    end else begin
      // Modest values, as a real mesh would give.
      c.px = ttg_pkg::POS_BITS'(int'($urandom_range(8191)) - 4096);
      c.py = ttg_pkg::POS_BITS'(int'($urandom_range(8191)) - 4096);
      c.pz = ttg_pkg::POS_BITS'(int'($urandom_range(8191)) - 4096);
      c.u = ttg_pkg::UV_BITS'(int'($urandom_range(4095)) - 2048);
      c.v = ttg_pkg::UV_BITS'(int'($urandom_range(4095)) - 2048);
      c.nx = ttg_pkg::NRM_BITS'(int'($urandom_range(131071)) - 65536);
      c.ny = ttg_pkg::NRM_BITS'(int'($urandom_range(131071)) - 65536);
      c.nz = ttg_pkg::NRM_BITS'(int'($urandom_range(131071)) - 65536);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_corner(input corner_row_t c);
    int g;
    g = gap_length();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1'b1;
    pos_x = c.px; pos_y = c.py; pos_z = c.pz;
    tex_u = c.u; tex_v = c.v;
    normal_x = c.nx; normal_y = c.ny; normal_z = c.nz;
    do @(posedge clk); while (in_stall);
    predict_corner(c);
    @(negedge clk);
  endtask

  // Sender.
  initial begin
    corner_row_t tri_corners[3];
    int mode;
    errors = 0;
    held_count = 0;
    sending_done = 1'b0;
    holdoff_req = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed[i]) send_corner(directed[i]);
    holdoff_req = 1'b1;
    for (int n = 0; n < RANDOM_TRIS; n++) begin
      mode = ($urandom_range(9) < 3) ? 0 : 1;
      for (int k = 0; k < 3; k++) tri_corners[k] = random_corner(mode);
      case ($urandom_range(9))
        0: tri_corners[2].u = tri_corners[0].u;  // may zero the determinant
        1: begin
          tri_corners[1].u = tri_corners[0].u;
          tri_corners[1].v = tri_corners[0].v;
        end
        2: begin
          tri_corners[1].px = tri_corners[0].px;
          tri_corners[1].py = tri_corners[0].py;
          tri_corners[1].pz = tri_corners[0].pz;
        end
        default: ;
      endcase
      for (int k = 0; k < 3; k++) send_corner(tri_corners[k]);
    end
    in_valid = 1'b0;
    sending_done = 1'b1;
  end

  // Receiver stall, with one long hold-off early in the random part.
  initial begin
    int g;
    bit held_off;
    held_off = 1'b0;
    @(negedge clk);
    forever begin
      if (holdoff_req && !held_off) begin
        held_off = 1'b1;
        out_stall = 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      g = gap_length();
      out_stall = (g > 0);
      repeat (g > 0 ? g : $urandom_range(6, 1)) @(negedge clk);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    tangent_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tangents.size() == 0) begin
        report_mismatch("unexpected word, corner", longint'(corner), -1);
      end else begin
        w = pending_tangents.pop_front();
        if (tangent_x !== w.tx)
          report_mismatch("tangent_x", longint'(tangent_x), longint'(w.tx));
        if (tangent_y !== w.ty)
          report_mismatch("tangent_y", longint'(tangent_y), longint'(w.ty));
        if (tangent_z !== w.tz)
          report_mismatch("tangent_z", longint'(tangent_z), longint'(w.tz));
        if (handedness !== w.hand)
          report_mismatch("handedness", longint'(handedness), longint'(w.hand));
        if (corner !== w.idx)
          report_mismatch("corner", longint'(corner), longint'(w.idx));
        if (last !== w.lst)
          report_mismatch("last", longint'(last), longint'(w.lst));
        if (degenerate !== w.deg)
          report_mismatch("degenerate", longint'(degenerate), longint'(w.deg));
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("triangle_tangent_generator verification failed");
        $finish;
      end
    end
  end

  initial begin
    wait (sending_done);
    while (pending_tangents.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_tangents.size() == 0) begin
      $display("triangle_tangent_generator verification clean");
    end else begin
      $display("triangle_tangent_generator verification failed");
    end
    $finish;
  end

endmodule
